[sv/dsc_pkg.sv]
// shared constants, suffix table and cell control type for the suffix classifier
`default_nettype none
package dsc_pkg;

  localparam int unsigned NumEntries = 39;
  localparam int unsigned EntryChars = 24;
  localparam int unsigned CodeW      = 4;
  localparam logic [7:0]  DotChar    = 8'h2E;

  typedef logic [EntryChars*8-1:0] entry_text_t;
  typedef logic [CodeW-1:0]        code_t;

  // control that every cell of the window sees in the same cycle
  typedef struct packed {
    logic shift;  // a byte beat is accepted, move the window by one
    logic clear;  // the name held in the window has been judged
  } cell_ctrl_t;

  // suffix strings, last character in the low byte
  localparam entry_text_t EntryText [NumEntries] = '{
    entry_text_t'("a-msedge.net"),
    entry_text_t'("akadns.net"),
    entry_text_t'("akadns6.net"),
    entry_text_t'({"aka", "mai.net"}),
    entry_text_t'({"aka", "maiedge.net"}),
    entry_text_t'({"amaz", "onaws.com"}),
    entry_text_t'("aol.com"),
    entry_text_t'("azurewebsites.net"),
    entry_text_t'("c-msedge.net"),
    entry_text_t'("cloudapp.net"),
    entry_text_t'({"cloudfl", "are.net"}),
    entry_text_t'("cloudfront.net"),
    entry_text_t'({"dis", "neyprivacycenter.com"}),
    entry_text_t'({"dis", "neytermsofuse.com"}),
    entry_text_t'("doubleclick.net"),
    entry_text_t'("e-msedge.net"),
    entry_text_t'("edgecastcdn.net"),
    entry_text_t'("elasticbeanstalk.com"),
    entry_text_t'("epsiloncdn.net"),
    entry_text_t'({"face", "book.com"}),
    entry_text_t'({"fast", "ly.net"}),
    entry_text_t'({"fast", "lylb.net"}),
    entry_text_t'("fbcdn.net"),
    entry_text_t'("footprint.net"),
    entry_text_t'("go.com"),
    entry_text_t'({"goo", "gle.com"}),
    entry_text_t'({"goo", "glehosted.com"}),
    entry_text_t'({"insta", "gram.com"}),
    entry_text_t'("itmdb.net"),
    entry_text_t'({"linked", "in.com"}),
    entry_text_t'("llnwd.net"),
    entry_text_t'({"micro", "soft.com"}),
    entry_text_t'("netdna-cdn.com"),
    entry_text_t'("nsatc.net"),
    entry_text_t'("s-msedge.net"),
    entry_text_t'("v0cdn.net"),
    entry_text_t'("v2cdn.net"),
    entry_text_t'({"yah", "oo.com"}),
    entry_text_t'({"yah", "oodns.net"})
  };

  localparam code_t EntryCode [NumEntries] = '{
    4'd7, 4'd1, 4'd1, 4'd1, 4'd1, 4'd6, 4'd9, 4'd7, 4'd7, 4'd7,
    4'd2, 4'd6, 4'd3, 4'd3, 4'd5, 4'd7, 4'd9, 4'd6, 4'd9, 4'd8,
    4'd4, 4'd4, 4'd8, 4'd10, 4'd3, 4'd5, 4'd5, 4'd8, 4'd10, 4'd7,
    4'd12, 4'd7, 4'd11, 4'd10, 4'd7, 4'd9, 4'd9, 4'd9, 4'd9
  };

  // number of characters in a suffix string, evaluated at elaboration
  function automatic int unsigned text_len(entry_text_t t);
    int unsigned n;
    logic        run;
    n   = 0;
    run = 1'b1;
    for (int unsigned i = 0; i < EntryChars; i++) begin
      if (run && (t[i*8 +: 8] != 8'h00)) begin
        n = n + 1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

[sv/dsc_cell.sv]
// one window cell: holds a byte, passes it on, and checks it against every suffix
`default_nettype none
module dsc_cell
  import dsc_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic [7:0]            byte_i,
  input  wire logic                  present_i,
  output logic [7:0]                 byte_o,
  output logic                       present_o,
  output logic [NumEntries-1:0]      hit_o
);

  logic [7:0] byte_q;
  logic       present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q    <= 8'h00;
      present_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      byte_q    <= byte_i;
      present_q <= present_i;
    end else if (ctrl_i.clear) begin
      byte_q    <= 8'h00;
      present_q <= 1'b0;
    end
  end

  assign byte_o    = byte_q;
  assign present_o = present_q;

  // inside a suffix: exact char; just past it: a dot or start of name
  for (genvar k = 0; k < NumEntries; k++) begin : g_entry
    localparam int unsigned Len = text_len(EntryText[k]);
    if (IDX < Len) begin : g_char
      assign hit_o[k] = (byte_q == EntryText[k][IDX*8 +: 8]);
    end else if (IDX == Len) begin : g_edge
      assign hit_o[k] = (byte_q == DotChar) || !present_q;
    end else begin : g_free
      assign hit_o[k] = 1'b1;
    end
  end

endmodule
`default_nettype wire

[sv/dsc_pick.sv]
// longest-match select over the suffix hit vector
`default_nettype none
module dsc_pick
  import dsc_pkg::*;
(
  input  wire logic [NumEntries-1:0] match_i,
  output code_t                      code_o
);

  logic [NumEntries-1:0] win;

  // matching entries are distinct strings, so no two of one length hit together
  for (genvar k = 0; k < NumEntries; k++) begin : g_win
    logic [NumEntries-1:0] longer;
    for (genvar j = 0; j < NumEntries; j++) begin : g_len
      if (text_len(EntryText[j]) > text_len(EntryText[k])) begin : g_yes
        assign longer[j] = match_i[j];
      end else begin : g_no
        assign longer[j] = 1'b0;
      end
    end
    assign win[k] = match_i[k] && !(|longer);
  end

  always_comb begin
    code_o = '0;
    for (int unsigned k = 0; k < NumEntries; k++) begin
      if (win[k]) begin
        code_o = code_o | EntryCode[k];
      end
    end
  end

endmodule
`default_nettype wire

[sv/domain_suffix_classifier.sv]
// top level: byte window of cells, suffix match stage and result queue
// result path: the tlast beat sets eval_q, which loads match_q and sets mv_q; mv_q writes the queue
// throughput: one name byte per cycle, names of any length back to back, one result
//   per name; tready drops only when four results are queued or in flight
// reset: rst_ni asynchronous active low, clears the window, the stage flags and the queue pointers
`default_nettype none
module domain_suffix_classifier
  import dsc_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 24
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input stream
  input  wire logic       s_tvalid_i,
  output logic            s_tready_o,
  input  wire logic [7:0] s_tdata_i,   // [7:0] name_byte
  input  wire logic       s_tlast_i,   // last_byte
  // result stream
  output logic            m_tvalid_o,
  input  wire logic       m_tready_i,
  output logic [7:0]      m_tdata_o    // [3:0] provider_code, [7:4] zero
);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  logic                  s_beat;
  logic                  m_beat;
  cell_ctrl_t            ctrl;

  // eval_q: window holds a complete name this cycle
  logic                  eval_q;
  // mv_q / match_q: per-suffix match result of the judged name
  logic                  mv_q;
  logic [NumEntries-1:0] match_d, match_q;

  logic [7:0]            cell_byte    [WINDOW_BYTES];
  logic                  cell_present [WINDOW_BYTES];
  logic [NumEntries-1:0] cell_hit     [WINDOW_BYTES];

  code_t                 pick_code;

  // result queue
  code_t                 fifo_mem [FifoDepth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       cnt_q;
  logic [CntW-1:0]       pending;

  assign s_beat = s_tvalid_i && s_tready_o;
  assign m_beat = m_tvalid_o && m_tready_i;

  // every name still to be answered holds a queue slot
  assign pending    = CntW'(eval_q) + CntW'(mv_q) + cnt_q;
  assign s_tready_o = (pending < CntW'(FifoDepth));

  assign ctrl.shift = s_beat;
  assign ctrl.clear = eval_q;

  // ---------------------------------------------------------------------------
  // window: newest byte in cell 0, each cell hands its byte to the next one;
  // after a name is judged the old bytes are dropped while a new byte may enter
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_cell
    logic [7:0] byte_in;
    logic       present_in;
    if (i == 0) begin : g_head
      assign byte_in    = s_tdata_i;
      assign present_in = 1'b1;
    end else begin : g_body
      assign byte_in    = eval_q ? 8'h00 : cell_byte[i-1];
      assign present_in = eval_q ? 1'b0 : cell_present[i-1];
    end
    dsc_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .byte_i    (byte_in),
      .present_i (present_in),
      .byte_o    (cell_byte[i]),
      .present_o (cell_present[i]),
      .hit_o     (cell_hit[i])
    );
  end

  // a suffix matches when every cell agrees
  always_comb begin
    match_d = '1;
    for (int unsigned i = 0; i < WINDOW_BYTES; i++) begin
      match_d = match_d & cell_hit[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q <= 1'b0;
      mv_q   <= 1'b0;
    end else begin
      eval_q <= s_beat && s_tlast_i;
      mv_q   <= eval_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_q) begin
      match_q <= match_d;
    end
  end

  dsc_pick u_pick (
    .match_i (match_q),
    .code_o  (pick_code)
  );

  // ---------------------------------------------------------------------------
  // result queue, written by the select stage, read by the output stream
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mv_q) begin
      fifo_mem[wr_ptr_q] <= pick_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (mv_q) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (m_beat) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(mv_q) - CntW'(m_beat);
    end
  end

  assign m_tvalid_o = (cnt_q != '0);
  assign m_tdata_o  = {(8 - CodeW)'(0), fifo_mem[rd_ptr_q]};

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("result queue count beyond depth");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_q |-> ((cnt_q < CntW'(FifoDepth)) || m_beat))
    else $error("result written into a full queue");

  a_eval_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_q |-> $past(s_beat && s_tlast_i))
    else $error("judge cycle without a last beat");

  a_window_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eval_q && !s_beat) |=> !cell_present[0])
    else $error("window not cleared after a name");

endmodule
`default_nettype wire

[test/tb_domain_suffix_classifier.sv]
// testbench for domain_suffix_classifier: random and directed names checked against a suffix predictor
module tb_domain_suffix_classifier;
  import dsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WinBytes    = 24;
  localparam int unsigned SuffixCount = 39;
  localparam int unsigned TextChars   = 24;
  localparam logic [7:0]  DotByte     = 8'h2E;
  localparam logic [4:0]  SeenMax     = 5'd31;
  localparam code_t       NoProvider  = '0;
  localparam int unsigned NameBytes   = 1650;

  typedef logic [TextChars*8-1:0] suffix_text_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } name_beat_t;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tready = 1'b0;
  wire logic  s_tready_o;
  wire logic  m_tvalid_o;
  wire logic [7:0] m_tdata_o;

  domain_suffix_classifier #(
    .WINDOW_BYTES(WinBytes)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata),     // [7:0] name_byte
    .s_tlast_i (s_tlast),     // last_byte
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready),
    .m_tdata_o (m_tdata_o)    // [3:0] provider_code, [7:4] zero
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // suffix list in table order, last character in the low byte
  suffix_text_t sfx_text [SuffixCount];
  code_t        sfx_code [SuffixCount];
  int unsigned  sfx_fill = 0;

  // predictor state: newest byte at index 0
  logic [7:0] win_bytes [WinBytes];
  logic [4:0] seen_cnt = '0;

  name_beat_t  beat_q [$];      // beats still to be offered
  logic [7:0]  name_buf [$];    // name under construction
  code_t       provider_q [$];  // verdicts owed by the block, oldest first

  int unsigned err_count   = 0;
  int unsigned bytes_taken = 0;
  int unsigned names_taken = 0;
  int unsigned verdicts    = 0;
  int unsigned hits        = 0;
  int unsigned tx_gap      = 0;
  int unsigned tx_calm     = 0;
  int unsigned tx_n        = 0;
  int unsigned rx_hold     = 0;
  int unsigned rx_calm     = 0;
  int unsigned rx_n        = 0;

  task automatic flag_mismatch(string what);
    err_count++;
    if (err_count <= 20) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  task automatic add_suffix(suffix_text_t txt, code_t code);
    sfx_text[sfx_fill] = txt;
    sfx_code[sfx_fill] = code;
    sfx_fill++;
  endtask

  function automatic int unsigned chars_in(suffix_text_t t);
    int unsigned n;
    n = 0;
    while (n < TextChars && t[n*8 +: 8] != 8'h00) n++;
    return n;
  endfunction

  // idle count per item, with occasional stretches of back-to-back items
  function automatic int unsigned pick_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(16, 64);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // longest label-aligned suffix of the name in the window that is in the list
  function automatic code_t judge_name();
    int unsigned best;
    int unsigned len;
    code_t       code;
    logic        hit;
    best = 0;
    code = NoProvider;
    for (int k = 0; k < SuffixCount; k++) begin
      len = chars_in(sfx_text[k]);
      hit = (len > best) && (len != 0) && (len <= seen_cnt) && (len <= WinBytes);
      for (int i = 0; i < len && hit; i++) begin
        if (win_bytes[i] != sfx_text[k][i*8 +: 8]) hit = 1'b0;
      end
      // a suffix shorter than the name must sit right after a dot
      if (hit && len != seen_cnt) hit = (len < WinBytes) && (win_bytes[len] == DotByte);
      if (hit) begin
        best = len;
        code = sfx_code[k];
      end
    end
    return code;
  endfunction

  task automatic take_beat(logic [7:0] b, logic last);
    code_t code;
    for (int i = WinBytes - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = b;
    if (seen_cnt != SeenMax) seen_cnt++;
    bytes_taken++;
    if (last) begin
      code = judge_name();
      provider_q.push_back(code);
      names_taken++;
      // the block starts a fresh name after the verdict
      foreach (win_bytes[i]) win_bytes[i] = 8'h00;
      seen_cnt = '0;
    end
  endtask

  task automatic check_result(logic [7:0] got);
    code_t want;
    verdicts++;
    if (provider_q.size() == 0) begin
      flag_mismatch($sformatf("verdict %0d: 0x%02h with no name pending", verdicts, got));
      return;
    end
    want = provider_q.pop_front();
    if (got[3:0] !== want) begin
      flag_mismatch($sformatf("verdict %0d: provider %0d, want %0d", verdicts, got[3:0], want));
    end
    if (got[7:4] !== 4'h0) begin
      flag_mismatch($sformatf("verdict %0d: pad bits 0x%01h not zero", verdicts, got[7:4]));
    end
    if (want != NoProvider) hits++;
  endtask

  // ---------------------------------------------------------------- name building

  function automatic logic [7:0] label_char();
    logic [7:0] r;
    r = $urandom_range(0, 36);
    if (r < 26) return 8'h61 + r;
    if (r < 36) return 8'h30 + r - 8'd26;
    return 8'h2D;
  endfunction

  task automatic put_label(int unsigned len);
    for (int i = 0; i < len; i++) name_buf.push_back(label_char());
  endtask

  task automatic put_text(suffix_text_t t);
    for (int i = int'(chars_in(t)) - 1; i >= 0; i--) name_buf.push_back(t[i*8 +: 8]);
  endtask

  // turns the built name into beats, tlast on its final byte
  task automatic send_name();
    name_beat_t nb;
    foreach (name_buf[i]) begin
      nb.data = name_buf[i];
      nb.last = (i == name_buf.size() - 1);
      beat_q.push_back(nb);
    end
    name_buf.delete();
  endtask

  task automatic random_name();
    int unsigned pick;
    int unsigned k;
    int unsigned start;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      // labels in front of a listed suffix, sometimes spoiled
      repeat ($urandom_range(0, 3)) begin
        put_label($urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 6));
        name_buf.push_back(DotByte);
      end
      if ($urandom_range(0, 3) == 0) begin
        // the longest entries push against the window edge
        case ($urandom_range(0, 3))
          0: k = 7;
          1: k = 12;
          2: k = 13;
          default: k = 17;
        endcase
      end else begin
        k = $urandom_range(0, SuffixCount - 1);
      end
      start = name_buf.size();
      put_text(sfx_text[k]);
      len = name_buf.size() - start;
      case ($urandom_range(0, 11))
        0: name_buf[start + $urandom_range(0, len - 1)] = label_char();
        1: name_buf.push_back(DotByte);                    // trailing dot
        2: name_buf.delete(start);                          // first char lost
        3: if (start > 0) name_buf.delete(start - 1);       // glued to the label before
        4: name_buf[start + $urandom_range(0, len - 1)] ^= 8'h20;  // case flipped
        default: ;
      endcase
    end else if (pick < 82) begin
      // ordinary names under common top-level labels, none listed
      repeat ($urandom_range(1, 4)) begin
        put_label($urandom_range(1, ($urandom_range(0, 3) == 0) ? 16 : 7));
        name_buf.push_back(DotByte);
      end
      case ($urandom_range(0, 3))
        0: put_text("net");
        1: put_text("com");
        2: put_text("msedge.net");
        default: put_text("cdn.net");
      endcase
    end else begin
      // raw bytes of any nonzero value, dots now and then
      repeat ($urandom_range(1, 40)) begin
        if ($urandom_range(0, 5) == 0) name_buf.push_back(DotByte);
        else name_buf.push_back(8'($urandom_range(1, 255)));
      end
    end
    send_name();
  endtask

  // ---------------------------------------------------------------- input side

  // offers queued beats, counts the idle cycles drawn for each one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tlast  <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (s_tvalid && s_tready_o) take_beat(s_tdata, s_tlast);
      if (!s_tvalid || s_tready_o) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          {s_tdata, s_tlast} <= beat_q.pop_front();
          s_tvalid <= 1'b1;
          tx_n      = pick_wait(tx_calm);
          tx_gap   <= tx_n;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result side

  // takes verdicts, then holds tready low for a drawn number of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
    end else if (m_tvalid_o && m_tready) begin
      check_result(m_tdata_o);
      rx_n = pick_wait(rx_calm);
      if (rx_n == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_hold  <= rx_n;
      end
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      if (rx_hold == 1) m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    add_suffix("a-msedge.net", 4'd7);
    add_suffix("akadns.net", 4'd1);
    add_suffix("akadns6.net", 4'd1);
    add_suffix({"aka", "mai.net"}, 4'd1);
    add_suffix({"aka", "maiedge.net"}, 4'd1);
    add_suffix({"amaz", "onaws.com"}, 4'd6);
    add_suffix("aol.com", 4'd9);
    add_suffix("azurewebsites.net", 4'd7);
    add_suffix("c-msedge.net", 4'd7);
    add_suffix("cloudapp.net", 4'd7);
    add_suffix({"cloudfl", "are.net"}, 4'd2);
    add_suffix("cloudfront.net", 4'd6);
    add_suffix({"dis", "neyprivacycenter.com"}, 4'd3);
    add_suffix({"dis", "neytermsofuse.com"}, 4'd3);
    add_suffix("doubleclick.net", 4'd5);
    add_suffix("e-msedge.net", 4'd7);
    add_suffix("edgecastcdn.net", 4'd9);
    add_suffix("elasticbeanstalk.com", 4'd6);
    add_suffix("epsiloncdn.net", 4'd9);
    add_suffix({"face", "book.com"}, 4'd8);
    add_suffix({"fast", "ly.net"}, 4'd4);
    add_suffix({"fast", "lylb.net"}, 4'd4);
    add_suffix("fbcdn.net", 4'd8);
    add_suffix("footprint.net", 4'd10);
    add_suffix("go.com", 4'd3);
    add_suffix({"goo", "gle.com"}, 4'd5);
    add_suffix({"goo", "glehosted.com"}, 4'd5);
    add_suffix({"insta", "gram.com"}, 4'd8);
    add_suffix("itmdb.net", 4'd10);
    add_suffix({"linked", "in.com"}, 4'd7);
    add_suffix("llnwd.net", 4'd12);
    add_suffix({"micro", "soft.com"}, 4'd7);
    add_suffix("netdna-cdn.com", 4'd11);
    add_suffix("nsatc.net", 4'd10);
    add_suffix("s-msedge.net", 4'd7);
    add_suffix("v0cdn.net", 4'd9);
    add_suffix("v2cdn.net", 4'd9);
    add_suffix({"yah", "oo.com"}, 4'd9);
    add_suffix({"yah", "oodns.net"}, 4'd9);
    foreach (win_bytes[i]) win_bytes[i] = 8'h00;

    // directed: one-byte names of the lowest nonzero and the highest byte, exact entry,
    // trailing dot, and a nul byte ahead of an aligned suffix
    name_buf.push_back(8'h01);
    send_name();
    name_buf.push_back(8'hFF);
    send_name();
    put_text("go.com");
    send_name();
    put_text("go.com.");
    send_name();
    name_buf.push_back(8'h00);
    put_text(".go.com");
    send_name();

    while (beat_q.size() < NameBytes) random_name();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (beat_q.size() != 0 || s_tvalid) @(negedge clk_i);
    while (provider_q.size() != 0) @(negedge clk_i);
    // room for a stray verdict to show up past the last stall
    repeat (40) @(negedge clk_i);

    $display("%0d name bytes in %0d names, %0d verdicts checked, %0d naming a provider",
             bytes_taken, names_taken, verdicts, hits);
    $display("names spanned listed, spoiled, unlisted and raw-byte forms up to 87 bytes");
    if (err_count == 0) begin
      $display("tb_domain_suffix_classifier: clean");
    end else begin
      $display("tb_domain_suffix_classifier: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d verdicts still owed", provider_q.size());
    $display("tb_domain_suffix_classifier: errors");
    $finish;
  end

endmodule
